// ===== sv/pnr_pkg.sv =====
// Shared types, constants and helpers for the polynomial Newton root finder.
// Depends on nothing; every file but pnr_ifs imports it.
package pnr_pkg;

    // Signed Q31.16 working word, saturated to +/-(2^47-1).
    typedef logic signed [47:0] t_q;
    localparam t_q QLIM  = 48'sh7FFF_FFFF_FFFF;
    localparam t_q Q_ONE = 48'sh0000_0001_0000;

    // Four 16-bit coefficient registers, x^0 first.
    typedef logic [3:0][15:0] t_coefs;

    // Result status codes.
    localparam logic [1:0] STAT_CONV  = 2'd0;
    localparam logic [1:0] STAT_DZERO = 2'd1;
    localparam logic [1:0] STAT_LIMIT = 2'd2;

    // Register indexes on the config port.
    localparam logic [2:0] REG_COEF0 = 3'd0;
    localparam logic [2:0] REG_COEF1 = 3'd1;
    localparam logic [2:0] REG_COEF2 = 3'd2;
    localparam logic [2:0] REG_COEF3 = 3'd3;
    localparam logic [2:0] REG_TOL   = 3'd4;
    localparam logic [2:0] REG_MAXIT = 3'd5;

    // Multiply kinds: power update, f term, f' term.
    localparam logic [1:0] K_POW = 2'd0;
    localparam logic [1:0] K_FT  = 2'd1;
    localparam logic [1:0] K_GT  = 2'd2;

    typedef struct packed {
        logic       load;
        logic       mul_go;
        logic [1:0] kind;
        logic       clr_f;
        logic       clr_g;
        logic       div_go;
        logic       upd_x;
        logic       zero_x;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic g_zero;
        logic f_ok;
    } t_sts;

    function automatic logic [47:0] qmag(input t_q v);
        return v[47] ? 48'(-v) : 48'(v);
    endfunction

    function automatic t_q sat_add(input t_q a, input t_q b);
        logic signed [48:0] s;
        s = 49'(a) + 49'(b);
        if (s > 49'(QLIM)) return QLIM;
        if (s < -49'(QLIM)) return -QLIM;
        return s[47:0];
    endfunction

endpackage

// ===== sv/pnr_ifs.sv =====
// Valid/ready channel interfaces for the root finder: guess in, result out.
// Depends on nothing.
interface pnr_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] start_x;
    modport source (output valid, output start_x, input ready);
    modport sink   (input valid, input start_x, output ready);
endinterface

interface pnr_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] root;
    logic [7:0]  iterations;
    logic [1:0]  status;
    modport source (output valid, output root, output iterations, output status, input ready);
    modport sink   (input valid, input root, input iterations, input status, output ready);
endinterface

// ===== sv/pnr_mul.sv =====
// Sequential Q16 multiplier: magnitude product 8 bits a cycle, >>16, capped, signed.
// Depends on pnr_pkg.
module pnr_mul (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  pnr_pkg::t_q   i_a,
    input  pnr_pkg::t_q   i_b,
    output logic          o_done,
    output pnr_pkg::t_q   o_res
);
    import pnr_pkg::*;

    localparam logic [2:0] LAST = 3'd5;   // six byte chunks of b

    logic         r_busy, r_done, r_neg;
    logic [2:0]   r_cnt;
    logic [47:0]  r_ua, r_ub;
    logic [95:0]  r_acc;
    logic [55:0]  w_part;
    logic [103:0] w_sum;
    logic [46:0]  w_mag;

    assign w_part = r_ua * r_ub[7:0];
    assign w_sum  = {8'b0, r_acc} + {w_part, 48'b0};
    assign w_mag  = (|r_acc[95:63]) ? QLIM[46:0] : r_acc[62:16];
    assign o_res  = r_neg ? -t_q'({1'b0, w_mag}) : t_q'({1'b0, w_mag});
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_acc  <= '0;
                r_ua   <= qmag(i_a);
                r_ub   <= qmag(i_b);
                r_neg  <= i_a[47] ^ i_b[47];
            end else if (r_busy) begin
                r_acc <= w_sum[103:8];
                r_ub  <= r_ub >> 8;
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

// ===== sv/pnr_div.sv =====
// Restoring divider for the Newton step: (|f| << 16) / |g|, one bit a cycle.
// Depends on pnr_pkg.
module pnr_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  pnr_pkg::t_q   i_f,
    input  pnr_pkg::t_q   i_g,
    output logic          o_done,
    output pnr_pkg::t_q   o_delta
);
    import pnr_pkg::*;

    localparam logic [5:0] LAST = 6'd62;   // 63 quotient bits

    logic         r_busy, r_done, r_neg;
    logic [5:0]   r_cnt;
    logic [47:0]  r_rem, r_den;
    logic [62:0]  r_num, r_quo;
    logic [47:0]  w_trial;
    logic         w_ge;
    logic [46:0]  w_mag;
    logic [47:0]  w_fm;

    assign w_fm    = qmag(i_f);
    assign w_trial = {r_rem[46:0], r_num[62]};
    assign w_ge    = w_trial >= r_den;
    assign w_mag   = (|r_quo[62:47]) ? QLIM[46:0] : r_quo[46:0];
    assign o_delta = r_neg ? -t_q'({1'b0, w_mag}) : t_q'({1'b0, w_mag});
    assign o_done  = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= '0;
                r_num  <= {w_fm[46:0], 16'b0};
                r_den  <= qmag(i_g);
                r_neg  <= i_f[47] ^ i_g[47];
            end else if (r_busy) begin
                r_rem <= w_ge ? (w_trial - r_den) : w_trial;
                r_quo <= {r_quo[61:0], w_ge};
                r_num <= r_num << 1;
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

// ===== sv/pnr_dp.sv =====
// Datapath: iterate x, powers of x, f and f' accumulators, multiplier and divider.
// Depends on pnr_pkg, pnr_mul, pnr_div.
module pnr_dp #(
    parameter int DEGREE = 3,
    parameter int IW     = $clog2(DEGREE + 2)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pnr_pkg::t_cmd    i_cmd,
    input  logic [IW-1:0]    i_idx,
    input  logic [31:0]      i_guess,
    input  pnr_pkg::t_coefs  i_coefs,
    input  logic [15:0]      i_tol,
    output pnr_pkg::t_sts    o_sts,
    output logic [31:0]      o_x
);
    import pnr_pkg::*;

    localparam int PW = (DEGREE < 2) ? 1 : $clog2(DEGREE + 1);

    logic signed [31:0] r_x;
    t_q                 r_p [0:DEGREE];
    t_q                 r_f, r_g;

    logic [PW-1:0]      w_ridx;
    logic [IW-1:0]      w_idxm1;
    logic signed [15:0] w_c;
    logic signed [18:0] w_ic;
    t_q                 w_a, w_b, w_xq, w_mres, w_delta;
    logic               w_mdone, w_ddone;
    logic signed [48:0] w_diff;
    logic signed [31:0] w_newx;

    assign w_idxm1 = i_idx - IW'(1);
    assign w_ridx  = (i_cmd.kind == K_FT) ? i_idx[PW-1:0] : w_idxm1[PW-1:0];
    assign w_c     = $signed(i_coefs[i_idx[1:0]]);
    assign w_ic    = $signed({1'b0, i_idx[1:0]}) * w_c;
    assign w_xq    = {{16{r_x[31]}}, r_x};

    always_comb begin
        case (i_cmd.kind)
            K_POW: begin
                w_a = r_p[w_ridx];
                w_b = w_xq;
            end
            K_FT: begin
                w_a = {{16{w_c[15]}}, w_c, 16'b0};
                w_b = r_p[w_ridx];
            end
            default: begin
                w_a = {{13{w_ic[18]}}, w_ic, 16'b0};
                w_b = r_p[w_ridx];
            end
        endcase
    end

    pnr_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.mul_go),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_done  (w_mdone),
        .o_res   (w_mres)
    );

    pnr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.div_go),
        .i_f     (r_f),
        .i_g     (r_g),
        .o_done  (w_ddone),
        .o_delta (w_delta)
    );

    // x - step, clamped to the 32-bit Q16.16 range
    assign w_diff = 49'(r_x) - 49'(w_delta);
    always_comb begin
        if (w_diff > 49'sd2147483647)
            w_newx = 32'sh7FFF_FFFF;
        else if (w_diff < -49'sd2147483648)
            w_newx = 32'sh8000_0000;
        else
            w_newx = w_diff[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x    <= i_guess;
            r_p[0] <= Q_ONE;
            r_p[1] <= {{16{i_guess[31]}}, i_guess};
        end
        if (i_cmd.upd_x) begin
            r_x    <= w_newx;
            r_p[1] <= {{16{w_newx[31]}}, w_newx};
        end
        if (i_cmd.zero_x)
            r_x <= '0;
        if (i_cmd.clr_f)
            r_f <= '0;
        if (i_cmd.clr_g)
            r_g <= '0;
        if (w_mdone) begin
            case (i_cmd.kind)
                K_POW:   r_p[i_idx[PW-1:0]] <= w_mres;
                K_FT:    r_f <= sat_add(r_f, w_mres);
                default: r_g <= sat_add(r_g, w_mres);
            endcase
        end
    end

    assign o_sts.mul_done = w_mdone;
    assign o_sts.div_done = w_ddone;
    assign o_sts.g_zero   = (r_g == '0);
    assign o_sts.f_ok     = qmag(r_f) <= {32'b0, i_tol};
    assign o_x            = r_x;
endmodule

// ===== sv/pnr_ctrl.sv =====
// Controller FSM: sequences power, f, f' and divide steps of each Newton iteration.
// Depends on pnr_pkg.
module pnr_ctrl #(
    parameter int DEGREE = 3,
    parameter int IW     = $clog2(DEGREE + 2)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  pnr_pkg::t_sts  i_sts,
    input  logic [7:0]     i_max_iter,
    output pnr_pkg::t_cmd  o_cmd,
    output logic [IW-1:0]  o_idx,
    input  logic           i_out_free,
    output logic           o_res_valid,
    output logic [7:0]     o_steps,
    output logic [1:0]     o_status
);
    import pnr_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_POW  = 3'd1;
    localparam logic [2:0] S_FT   = 3'd2;
    localparam logic [2:0] S_CHKF = 3'd3;
    localparam logic [2:0] S_GT   = 3'd4;
    localparam logic [2:0] S_CHKG = 3'd5;
    localparam logic [2:0] S_DIV  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    localparam logic [IW-1:0] IDX_MAX = IW'(DEGREE);

    logic [2:0]    r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic          r_wait, n_wait;
    logic          r_first, n_first;
    logic [7:0]    r_steps, n_steps;
    logic [1:0]    r_status, n_status;

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_wait   = r_wait;
        n_first  = r_first;
        n_steps  = r_steps;
        n_status = r_status;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_idx      = IW'(2);
                    n_wait     = 1'b0;
                    n_first    = 1'b1;
                    n_steps    = '0;
                    n_state    = S_POW;
                end
            end
            S_POW, S_FT, S_GT: begin
                o_cmd.kind = (r_state == S_POW) ? K_POW : (r_state == S_FT) ? K_FT : K_GT;
                if (r_idx > IDX_MAX) begin
                    if (r_state == S_POW) begin
                        o_cmd.clr_f = 1'b1;
                        n_idx       = '0;
                        n_state     = S_FT;
                    end else if (r_state == S_FT) begin
                        n_state = S_CHKF;
                    end else begin
                        n_state = S_CHKG;
                    end
                end else if (!r_wait) begin
                    o_cmd.mul_go = 1'b1;
                    n_wait       = 1'b1;
                end else if (i_sts.mul_done) begin
                    n_idx  = r_idx + IW'(1);
                    n_wait = 1'b0;
                end
            end
            S_CHKF: begin
                if (!r_first && i_sts.f_ok) begin
                    n_status = STAT_CONV;
                    n_state  = S_OUT;
                end else if (!r_first && r_steps >= i_max_iter) begin
                    n_status = STAT_LIMIT;
                    n_state  = S_OUT;
                end else begin
                    o_cmd.clr_g = 1'b1;
                    n_first     = 1'b0;
                    n_idx       = IW'(1);
                    n_steps     = r_steps + 8'd1;
                    n_state     = S_GT;
                end
            end
            S_CHKG: begin
                if (i_sts.g_zero) begin
                    o_cmd.zero_x = 1'b1;
                    n_status     = STAT_DZERO;
                    n_state      = S_OUT;
                end else begin
                    o_cmd.div_go = 1'b1;
                    n_state      = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.upd_x = 1'b1;
                    n_idx       = IW'(2);
                    n_state     = S_POW;
                end
            end
            S_OUT: begin
                if (i_out_free)
                    n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait  <= 1'b0;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wait  <= n_wait;
            r_first <= n_first;
        end
        r_idx    <= n_idx;
        r_steps  <= n_steps;
        r_status <= n_status;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_idx       = r_idx;
    assign o_res_valid = (r_state == S_OUT);
    assign o_steps     = r_steps;
    assign o_status    = r_status;
endmodule

// ===== sv/polynomial_newton_root_finder.sv =====
// Top level of the Newton-Raphson polynomial root finder: config registers,
// controller, datapath and result register. Depends on pnr_pkg, pnr_ifs, pnr_ctrl, pnr_dp.
//
//  channel   dir  handshake          payload
//  i_item    in   valid/ready        start_x  s32 Q16.16
//  o_result  out  valid/ready        root s32 Q16.16, iterations u8, status u2
//  config    in   i_cfg_we (no wait) i_cfg_idx 3b, i_cfg_data 16b
//
// One item at a time. A multiply runs issue, six byte steps, done; the divide runs
// issue, 63 quotient bits, done. Accepting a guess loads x and forms the powers of x
// and f at it; each Newton step forms f', divides, updates x and forms the powers and f
// again, up to max_iterations steps (at least one), and then the result is parked.
// Reset is synchronous, active low; it clears control and loads register defaults.
// A waiting result sits in the output register; a new transaction is accepted
// meanwhile, and the controller stalls only if the next result finds it still full.
module polynomial_newton_root_finder #(
    parameter int DEGREE = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    pnr_in_if.sink           i_item,
    pnr_out_if.source        o_result,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_idx,
    input  logic [15:0]      i_cfg_data
);
    import pnr_pkg::*;

    localparam int IW = $clog2(DEGREE + 2);

    t_coefs        r_coefs;
    logic [15:0]   r_tol;
    logic [7:0]    r_max;

    t_cmd          w_cmd;
    t_sts          w_sts;
    logic [IW-1:0] w_idx;
    logic [31:0]   w_x;
    logic          w_res_valid, w_out_free;
    logic [7:0]    w_steps;
    logic [1:0]    w_status;

    logic          r_out_valid;
    logic [31:0]   r_root;
    logic [7:0]    r_iter;
    logic [1:0]    r_stat;

    // Config register file; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs <= '0;
            r_tol   <= 16'd7;
            r_max   <= 8'd32;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_COEF0: r_coefs[0] <= i_cfg_data;
                REG_COEF1: r_coefs[1] <= i_cfg_data;
                REG_COEF2: r_coefs[2] <= i_cfg_data;
                REG_COEF3: r_coefs[3] <= i_cfg_data;
                REG_TOL:   r_tol      <= i_cfg_data;
                REG_MAXIT: r_max      <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    pnr_ctrl #(.DEGREE(DEGREE), .IW(IW)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .i_sts       (w_sts),
        .i_max_iter  (r_max),
        .o_cmd       (w_cmd),
        .o_idx       (w_idx),
        .i_out_free  (w_out_free),
        .o_res_valid (w_res_valid),
        .o_steps     (w_steps),
        .o_status    (w_status)
    );

    pnr_dp #(.DEGREE(DEGREE), .IW(IW)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_idx   (w_idx),
        .i_guess (i_item.start_x),
        .i_coefs (r_coefs),
        .i_tol   (r_tol),
        .o_sts   (w_sts),
        .o_x     (w_x)
    );

    // Output register: frees the controller as soon as a result is parked.
    assign w_out_free = !r_out_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_res_valid && w_out_free) begin
            r_root <= w_x;
            r_iter <= w_steps;
            r_stat <= w_status;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.root       = r_root;
    assign o_result.iterations = r_iter;
    assign o_result.status     = r_stat;
endmodule

// ===== sv/pnr_checker.sv =====
// Port-level checks for the root finder, bound onto the top level.
// Depends on pnr_pkg and polynomial_newton_root_finder.
module pnr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_root,
    input logic [7:0]  i_iter,
    input logic [1:0]  i_status
);
    import pnr_pkg::*;

    // Result waits until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // A legal status only.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status == STAT_CONV || i_status == STAT_DZERO
                         || i_status == STAT_LIMIT))
        else $error("bad status code");

    // At least one step is always made.
    a_iter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_iter != 8'd0)
        else $error("zero iteration count");

    // Zero derivative reports root zero.
    a_dzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == STAT_DZERO |-> i_root == 32'd0)
        else $error("nonzero root on zero derivative");

    // Busy right after taking a guess.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("accepted a second guess while busy");
endmodule

bind polynomial_newton_root_finder pnr_checker u_pnr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_root      (o_result.root),
    .i_iter      (o_result.iterations),
    .i_status    (o_result.status)
);
